// ----- src/rrse_pkg.sv -----
// Shared types, constants and helpers of the rectangle region set engine.
// Depends on nothing; rrse_cut and the core refer to it by scoped names.
`default_nettype none
package rrse_pkg;

  localparam int CAPACITY  = 256;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int ADDR_BITS = IDX_BITS + 1;

  localparam logic [2:0] FN_CLEAR     = 3'd0;
  localparam logic [2:0] FN_ASSIGN    = 3'd1;
  localparam logic [2:0] FN_INCLUDE   = 3'd2;
  localparam logic [2:0] FN_EXCLUDE   = 3'd3;
  localparam logic [2:0] FN_INTERSECT = 3'd4;
  localparam logic [2:0] FN_QOVER     = 3'd5;
  localparam logic [2:0] FN_QPOINT    = 3'd6;
  localparam logic [2:0] FN_READ      = 3'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CAP = 2'd1;
  localparam logic [1:0] ST_IDX = 2'd2;

  typedef struct packed {
    logic signed [31:0] l;
    logic signed [31:0] t;
    logic signed [31:0] r;
    logic signed [31:0] b;
  } rect_t;

  typedef struct packed {
    logic             overlap;
    logic [3:0]       valid;
    rect_t [3:0]      pcs;
    logic             clip_ok;
    rect_t            clip;
  } cut_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/rrse_ram.sv -----
// Generic single-write, single-read synchronous RAM, read data registered.
// No dependencies.
`default_nettype none
module rrse_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/rrse_cut.sv -----
// Geometry unit: splits a stored rectangle around an operand, clips it, tests overlap.
// Depends on rrse_pkg.
`default_nettype none
module rrse_cut (
  input  wire rrse_pkg::rect_t a,
  input  wire rrse_pkg::rect_t o,
  output rrse_pkg::cut_t       res
);
  logic signed [31:0] at2, ab2;
  logic               apart;

  always_comb begin
    apart = (o.r <= a.l) || (a.r <= o.l) || (o.b <= a.t) || (a.b <= o.t);
    at2 = (o.t > a.t) ? o.t : a.t;
    ab2 = (o.b < a.b) ? o.b : a.b;
    res.overlap = !apart;
    res.pcs[0] = a;
    res.pcs[1] = '{l: a.l, t: o.b, r: a.r, b: a.b};
    res.pcs[2] = '{l: a.l, t: at2, r: o.l, b: ab2};
    res.pcs[3] = '{l: o.r, t: at2, r: a.r, b: ab2};
    if (apart) begin
      res.valid = 4'b0001;
    end else begin
      res.pcs[0] = '{l: a.l, t: a.t, r: a.r, b: o.t};
      res.valid  = {o.r < a.r, o.l > a.l, o.b < a.b, o.t > a.t};
    end
    res.clip.l = (a.l > o.l) ? a.l : o.l;
    res.clip.t = (a.t > o.t) ? a.t : o.t;
    res.clip.r = (a.r < o.r) ? a.r : o.r;
    res.clip.b = (a.b < o.b) ? a.b : o.b;
    res.clip_ok = (res.clip.l <= res.clip.r) && (res.clip.t <= res.clip.b);
  end
endmodule
`default_nettype wire

// ----- src/rectangle_region_set_engine_core.sv -----
// Top level of the rectangle region set engine: operation sequencer and tables.
// Depends on rrse_pkg, rrse_ram and rrse_cut.
//
// Usage: raise start with func and operands while busy is low; that edge is the
// transfer. busy stays high while the operation runs. The result appears on
// hit, rect_count, out_* and status for exactly one cycle with done high; the
// receiver cannot stall it. A new start may be taken in the done cycle.
// Clear, assign, a read out of range and a non-include op on an empty region
// finish from idle; an entry read waits for the registered table read. Queries
// and intersect take each stored entry in turn, exclude emits the parts of each
// entry outside the operand, and include cuts each piece in play around each
// entry and appends what is left. A capacity error ends exclude or include early.
// The rate is set by the one read port of each table: every stored entry or
// piece is fetched once per pass and each resulting piece takes one write.
// The region table holds two banks that trade roles after exclude and
// intersect; the piece table holds two banks that alternate during include.
// Reset empties the region (count zero, bank zero) at once; table contents
// are left as they are.
`default_nettype none
module rectangle_region_set_engine_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] rect_left,
  input  wire logic signed [31:0] rect_top,
  input  wire logic signed [31:0] rect_width,
  input  wire logic signed [31:0] rect_height,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic [7:0]         entry_index,
  output logic                    done,
  output logic                    hit,
  output logic [8:0]              rect_count,
  output logic signed [31:0]      out_left,
  output logic signed [31:0]      out_top,
  output logic signed [31:0]      out_right,
  output logic signed [31:0]      out_bottom,
  output logic [1:0]              status
);
  localparam int CB = rrse_pkg::CNT_BITS;
  localparam int IB = rrse_pkg::IDX_BITS;
  localparam int AB = rrse_pkg::ADDR_BITS;
  localparam int RW = $bits(rrse_pkg::rect_t);
  localparam logic [CB-1:0] CAP = CB'(rrse_pkg::CAPACITY);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDWAIT   = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_LAT = 4'd3;
  localparam logic [3:0] S_EVAL     = 4'd4;
  localparam logic [3:0] S_EMIT     = 4'd5;
  localparam logic [3:0] S_INC_RD   = 4'd6;
  localparam logic [3:0] S_INC_LAT  = 4'd7;
  localparam logic [3:0] S_INC_END  = 4'd8;
  localparam logic [3:0] S_CP_RD    = 4'd9;
  localparam logic [3:0] S_CP_WR    = 4'd10;

  logic [3:0]         state;
  logic [2:0]         func_r;
  logic signed [31:0] px, py;
  rrse_pkg::rect_t    cop, a, in_rect;
  logic [CB-1:0]      count, i, k, kn, m, pcount, m_next;
  logic               bank, pb;
  logic [1:0]         step;
  rrse_pkg::cut_t     cut;
  logic               put, last, is_inc;
  logic [CB:0]        total;

  logic          r_we, p_we;
  logic [AB-1:0] r_waddr, r_raddr, p_waddr, p_raddr;
  logic [RW-1:0] r_wdata, p_wdata, r_rdata, p_rdata;
  rrse_pkg::rect_t r_rect, p_rect;

  rrse_ram #(.DEPTH(2 * rrse_pkg::CAPACITY), .WIDTH(RW)) u_region (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  rrse_ram #(.DEPTH(2 * rrse_pkg::CAPACITY), .WIDTH(RW)) u_piece (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  rrse_cut u_cut (.a(a), .o(cop), .res(cut));

  assign r_rect     = r_rdata;
  assign p_rect     = p_rdata;
  assign busy       = (state != S_IDLE);
  assign rect_count = count;
  assign is_inc     = (func_r == rrse_pkg::FN_INCLUDE);
  assign last       = ((k + 1'b1) == kn);
  assign m_next     = m + CB'(put);
  assign total      = {1'b0, count} + {1'b0, pcount};

  always_comb begin
    in_rect.l = rect_left;
    in_rect.t = rect_top;
    in_rect.r = rrse_pkg::sat_add(rect_left, rect_width);
    in_rect.b = rrse_pkg::sat_add(rect_top, rect_height);
  end

  always_comb begin
    r_we    = 1'b0;
    p_we    = 1'b0;
    put     = 1'b0;
    r_waddr = {~bank, m[IB-1:0]};
    p_waddr = {~pb, m[IB-1:0]};
    r_wdata = cut.pcs[step];
    p_wdata = cut.pcs[step];
    r_raddr = {bank, k[IB-1:0]};
    p_raddr = {pb, k[IB-1:0]};
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == rrse_pkg::FN_ASSIGN) begin
            r_we    = 1'b1;
            r_waddr = {bank, IB'(0)};
            r_wdata = in_rect;
          end
          if (func == rrse_pkg::FN_INCLUDE) begin
            p_we    = 1'b1;
            p_waddr = '0;
            p_wdata = in_rect;
          end
          r_raddr = {bank, entry_index[IB-1:0]};
        end
      end
      S_INC_RD: r_raddr = {bank, i[IB-1:0]};
      S_EVAL: begin
        if (func_r == rrse_pkg::FN_INTERSECT && cut.clip_ok) begin
          put     = 1'b1;
          r_we    = 1'b1;
          r_wdata = cut.clip;
        end
      end
      S_EMIT: begin
        if (cut.valid[step] && m != CAP) begin
          put  = 1'b1;
          r_we = !is_inc;
          p_we = is_inc;
        end
      end
      S_CP_WR: begin
        r_we    = 1'b1;
        r_waddr = {bank, count[IB-1:0] + k[IB-1:0]};
        r_wdata = p_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      bank  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_r     <= func;
            cop        <= in_rect;
            px         <= point_x;
            py         <= point_y;
            hit        <= 1'b0;
            status     <= rrse_pkg::ST_OK;
            out_left   <= '0;
            out_top    <= '0;
            out_right  <= '0;
            out_bottom <= '0;
            i          <= '0;
            k          <= '0;
            m          <= '0;
            kn         <= count;
            pb         <= 1'b0;
            pcount     <= CB'(1);
            unique case (func)
              rrse_pkg::FN_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              rrse_pkg::FN_ASSIGN: begin
                count <= CB'(1);
                done  <= 1'b1;
              end
              rrse_pkg::FN_READ: begin
                if ({1'b0, entry_index[IB-1:0]} < count) begin
                  state <= S_RDWAIT;
                end else begin
                  status <= rrse_pkg::ST_IDX;
                  done   <= 1'b1;
                end
              end
              rrse_pkg::FN_INCLUDE: begin
                state <= (count == '0) ? S_INC_END : S_INC_RD;
              end
              default: begin
                if (count != '0) begin
                  state <= S_SCAN_RD;
                end else begin
                  if (func == rrse_pkg::FN_EXCLUDE || func == rrse_pkg::FN_INTERSECT) begin
                    bank <= ~bank;
                  end
                  done <= 1'b1;
                end
              end
            endcase
          end
        end
        S_RDWAIT: begin
          out_left   <= r_rect.l;
          out_top    <= r_rect.t;
          out_right  <= r_rect.r;
          out_bottom <= r_rect.b;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_SCAN_RD: state <= S_SCAN_LAT;
        S_SCAN_LAT: begin
          a    <= is_inc ? p_rect : r_rect;
          step <= '0;
          state <= (is_inc || func_r == rrse_pkg::FN_EXCLUDE) ? S_EMIT : S_EVAL;
        end
        S_EVAL, S_EMIT: begin
          if (state == S_EVAL && func_r == rrse_pkg::FN_QOVER && cut.overlap) begin
            hit <= 1'b1;
          end
          if (state == S_EVAL && func_r == rrse_pkg::FN_QPOINT &&
              a.l <= px && px < a.r && a.t <= py && py <= a.b) begin
            hit <= 1'b1;
          end
          if (state == S_EMIT && cut.valid[step] && m == CAP) begin
            status <= rrse_pkg::ST_CAP;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            m <= m_next;
            if (state == S_EMIT && step != 2'd3) begin
              step <= step + 1'b1;
            end else if (!last) begin
              k     <= k + 1'b1;
              state <= S_SCAN_RD;
            end else if (is_inc) begin
              pb     <= ~pb;
              pcount <= m_next;
              i      <= i + 1'b1;
              state  <= ((i + 1'b1) == count) ? S_INC_END : S_INC_RD;
            end else begin
              if (func_r == rrse_pkg::FN_EXCLUDE || func_r == rrse_pkg::FN_INTERSECT) begin
                count <= m_next;
                bank  <= ~bank;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_INC_RD: state <= S_INC_LAT;
        S_INC_LAT: begin
          cop <= r_rect;
          k   <= '0;
          m   <= '0;
          kn  <= pcount;
          if (pcount != '0) begin
            state <= S_SCAN_RD;
          end else begin
            i     <= i + 1'b1;
            state <= ((i + 1'b1) == count) ? S_INC_END : S_INC_RD;
          end
        end
        S_INC_END: begin
          k <= '0;
          if (total > {1'b0, CAP}) begin
            status <= rrse_pkg::ST_CAP;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (pcount == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_CP_RD;
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          if ((k + 1'b1) == pcount) begin
            count <= total[CB-1:0];
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_CP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
